>>> hw/rtl/base64_stream_encoder_macros.svh
// Assertion helpers for the checker file.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Concurrent check, muted while reset is high.
`define B64_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define B64_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/b64_pkg.sv
`default_nettype none

package b64_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int SLOT_COUNT          = 4;
   localparam int SLOT_IDX_W          = $clog2(SLOT_COUNT);

   localparam logic [6:0] PAD_CHAR = 7'h3D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] code_char;
      logic       end_of_code;
   } rsp_type;

   typedef struct packed {
      logic       is_pad;
      logic [5:0] sextet;
   } slot_type;

   // Work for one input byte: characters in slot order, up to last_idx.
   typedef struct packed {
      slot_type [SLOT_COUNT-1:0] slots;
      logic [SLOT_IDX_W-1:0]     last_idx;
      logic                      fin;
   } job_type;

   // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
   function automatic logic [6:0] to_ascii(input logic [5:0] v);
      logic [6:0] ch;
      if (v < 6'd26) begin
         ch = 7'h41 + {1'b0, v};
      end else if (v < 6'd52) begin
         ch = 7'h61 + {1'b0, v - 6'd26};
      end else if (v < 6'd62) begin
         ch = 7'h30 + {1'b0, v - 6'd52};
      end else if (v == 6'd62) begin
         ch = 7'h2B;
      end else begin
         ch = 7'h2F;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/b64_front.sv
`default_nettype none

module b64_front
   import b64_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    queue_full,
   output logic         push,
   output job_type      push_job
);

   typedef enum logic [1:0] {
      PH0 = 2'd0,
      PH1 = 2'd1,
      PH2 = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] left_ff, left_in;

   logic [7:0] b;
   logic       fin;

   assign b         = req_data.data_byte;
   assign fin       = req_data.final_byte;
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_job     = '0;
      push_job.fin = fin;
      phase_in     = phase_ff;
      left_in      = left_ff;
      unique case (phase_ff)
         PH1: begin
            push_job.slots[0].sextet = {left_ff[1:0], b[7:4]};
            if (fin) begin
               push_job.slots[1].sextet = {b[3:0], 2'b00};
               push_job.slots[2].is_pad = 1'b1;
               push_job.last_idx        = SLOT_IDX_W'(2);
            end
            left_in  = b[3:0];
            phase_in = PH2;
         end
         PH2: begin
            push_job.slots[0].sextet = {left_ff, b[7:6]};
            push_job.slots[1].sextet = b[5:0];
            push_job.last_idx        = SLOT_IDX_W'(1);
            left_in  = 4'd0;
            phase_in = PH0;
         end
         default: begin
            // unused phase code behaves as the start of a group
            push_job.slots[0].sextet = b[7:2];
            if (fin) begin
               push_job.slots[1].sextet = {b[1:0], 4'b0000};
               push_job.slots[2].is_pad = 1'b1;
               push_job.slots[3].is_pad = 1'b1;
               push_job.last_idx        = SLOT_IDX_W'(3);
            end
            left_in  = {2'b00, b[1:0]};
            phase_in = PH1;
         end
      endcase
      if (fin) begin
         left_in  = 4'd0;
         phase_in = PH0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH0;
         left_ff  <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/b64_queue.sv
`default_nettype none

module b64_queue
   import b64_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   output logic         head_valid,
   output job_type      head_job,
   input  wire logic    pop
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type       mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/b64_back.sv
`default_nettype none

module b64_back
   import b64_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire job_type head_job,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic [SLOT_IDX_W-1:0] idx_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_data_in;
   slot_type              cur_slot;
   logic                  load;
   logic                  at_last;

   assign load     = head_valid && (!rsp_valid_ff || rsp_ready);
   assign cur_slot = head_job.slots[idx_ff];
   assign at_last  = (idx_ff == head_job.last_idx);
   assign pop      = load && at_last;

   always_comb begin
      rsp_data_in.code_char   = cur_slot.is_pad ? PAD_CHAR : to_ascii(cur_slot.sextet);
      rsp_data_in.end_of_code = head_job.fin && at_last;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= at_last ? '0 : idx_ff + 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/base64_stream_encoder.sv
// Base64 (standard alphabet, '=' padding) encoder over a byte stream. A byte
// is taken whenever the internal job queue has room, split into its 6-bit
// groups at once and queued as one job of one to four characters, so new
// bytes are taken while earlier jobs are still being sent. The output side
// sends one character per cycle from the head job while rsp_ready is high; a
// three-byte group yields four characters, and a final byte up to four
// for its tail and padding. A byte's job is registered in the queue, then its
// characters in the output register. A final byte closes the message and the
// next byte starts a new one; end_of_code marks the last character.
`default_nettype none

module base64_stream_encoder
   import b64_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    head_valid;
   job_type head_job;
   logic    pop;

   b64_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   b64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   b64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

>>> hw/rtl/b64_checker.sv
`default_nettype none
`include "base64_stream_encoder_macros.svh"

module b64_checker
   import b64_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // position of the next character within its group of four
   logic [1:0] pos_ff;
   logic       beat;

   assign beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
      end else if (beat) begin
         pos_ff <= rsp_data.end_of_code ? 2'd0 : pos_ff + 2'd1;
      end
   end

   `B64_ASSERT_RST(a_reset_idle, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `B64_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled beat changed")

   `B64_ASSERT(a_end_aligned, clock, reset,
      beat && rsp_data.end_of_code |-> pos_ff == 2'd3, "message length not a multiple of four")

   `B64_ASSERT(a_pad_place, clock, reset,
      beat && rsp_data.code_char == PAD_CHAR && !rsp_data.end_of_code |-> pos_ff == 2'd2,
      "inner padding out of place")

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
